// File: design/dpfrc_pkg.sv
// ----------------------------------------------------------------------------
// dpfrc_pkg: shared types and constants
// Request codes, default sizes and the ring control bundle for the
// duplicate-filtering packet FIFO.
// ----------------------------------------------------------------------------
package dpfrc_pkg;

  // default sizes
  localparam int DEPTH_DEF     = 1024;
  localparam int NODE_BITS_DEF = 16;
  localparam int TIME_BITS_DEF = 32;

  // request kinds
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_FWD   = 2'd1;
  localparam logic [1:0] REQ_COUNT = 2'd2;

  // register word indexes
  localparam logic REG_CAPACITY = 1'b0;

  // control from the sequencer to the ring of cells
  typedef struct packed {
    logic shift;
    logic load;
  } ring_ctrl_t;

endpackage

// File: design/dpfrc_cell.sv
// ----------------------------------------------------------------------------
// dpfrc_cell: one record slot of the ring
// Holds one record; rotates it on to the neighbor or loads a new record.
// ----------------------------------------------------------------------------
module dpfrc_cell #(
  parameter int NODE_BITS = dpfrc_pkg::NODE_BITS_DEF,
  parameter int TIME_BITS = dpfrc_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 shift,
  input  logic                 load,
  input  logic [NODE_BITS-1:0] in_src,
  input  logic [NODE_BITS-1:0] in_dst,
  input  logic [TIME_BITS-1:0] in_time,
  input  logic [NODE_BITS-1:0] ld_src,
  input  logic [NODE_BITS-1:0] ld_dst,
  input  logic [TIME_BITS-1:0] ld_time,
  output logic [NODE_BITS-1:0] rec_src,
  output logic [NODE_BITS-1:0] rec_dst,
  output logic [TIME_BITS-1:0] rec_time
);
  import dpfrc_pkg::*;

  // record storage, written on load or passed along on shift
  always_ff @(posedge clk) begin
    if (load) begin
      rec_src  <= ld_src;
      rec_dst  <= ld_dst;
      rec_time <= ld_time;
    end else if (shift) begin
      rec_src  <= in_src;
      rec_dst  <= in_dst;
      rec_time <= in_time;
    end
  end

endmodule

// File: design/dpfrc_ring.sv
// ----------------------------------------------------------------------------
// dpfrc_ring: rotating chain of record cells
// Cell i takes from cell i+1 on each shift, the last cell from cell 0.
// Cell 0 is the observation tap. A load writes one slot by index.
// ----------------------------------------------------------------------------
module dpfrc_ring #(
  parameter int DEPTH     = dpfrc_pkg::DEPTH_DEF,
  parameter int NODE_BITS = dpfrc_pkg::NODE_BITS_DEF,
  parameter int TIME_BITS = dpfrc_pkg::TIME_BITS_DEF,
  parameter int PTR_W     = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  dpfrc_pkg::ring_ctrl_t  ctrl,
  input  logic [PTR_W-1:0]       wr_slot,
  input  logic [NODE_BITS-1:0]   wr_src,
  input  logic [NODE_BITS-1:0]   wr_dst,
  input  logic [TIME_BITS-1:0]   wr_time,
  output logic [NODE_BITS-1:0]   tap_src,
  output logic [NODE_BITS-1:0]   tap_dst,
  output logic [TIME_BITS-1:0]   tap_time
);
  import dpfrc_pkg::*;

  logic [NODE_BITS-1:0] c_src  [DEPTH];
  logic [NODE_BITS-1:0] c_dst  [DEPTH];
  logic [TIME_BITS-1:0] c_time [DEPTH];

  // chain of cells, closed into a ring
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int NXT = (i + 1) % DEPTH;
    logic ld;

    // slot write decode
    assign ld = ctrl.load && (wr_slot == PTR_W'(i));

    dpfrc_cell #(
      .NODE_BITS(NODE_BITS),
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk     (clk),
      .shift   (ctrl.shift),
      .load    (ld),
      .in_src  (c_src[NXT]),
      .in_dst  (c_dst[NXT]),
      .in_time (c_time[NXT]),
      .ld_src  (wr_src),
      .ld_dst  (wr_dst),
      .ld_time (wr_time),
      .rec_src (c_src[i]),
      .rec_dst (c_dst[i]),
      .rec_time(c_time[i])
    );
  end

  // tap at cell 0
  assign tap_src  = c_src[0];
  assign tap_dst  = c_dst[0];
  assign tap_time = c_time[0];

endmodule

// File: design/dedup_packet_fifo_with_range_count_top.sv
// ----------------------------------------------------------------------------
// dedup_packet_fifo_with_range_count_top: duplicate-filtering packet FIFO
// Holds records in arrival order up to a programmable capacity; add, forward
// and range-count requests, all served by one rotation of the record ring.
// ----------------------------------------------------------------------------
// Every request is taken, then the ring of record cells makes one full turn
// past a single comparator at the tap, and then the request is committed;
// the result strobe done is high for one cycle at the end and must be taken
// then, since the receiver has no way to hold it. busy stays high from the
// transfer of start until that strobe, and start is accepted again in the
// same cycle as done. The scan length is set by the ring length: each stored
// record is compared once per request. There is no clearing pass after
// reset; capacity writes must go through the register port only while no
// request is in flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module dedup_packet_fifo_with_range_count_top #(
  parameter int DEPTH     = dpfrc_pkg::DEPTH_DEF,
  parameter int NODE_BITS = dpfrc_pkg::NODE_BITS_DEF,
  parameter int TIME_BITS = dpfrc_pkg::TIME_BITS_DEF,
  parameter int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // request
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type,
  input  logic [NODE_BITS-1:0] src_node,
  input  logic [NODE_BITS-1:0] dst_node,
  input  logic [TIME_BITS-1:0] pkt_time,
  input  logic [TIME_BITS-1:0] range_start,
  input  logic [TIME_BITS-1:0] range_end,
  // result
  output logic                 done,
  output logic                 accepted,
  output logic [NODE_BITS-1:0] out_src,
  output logic [NODE_BITS-1:0] out_dst,
  output logic [TIME_BITS-1:0] out_time,
  output logic [CNT_W-1:0]     match_count
);
  import dpfrc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]           state;
  logic [PTR_W-1:0]     head;
  logic [CNT_W-1:0]     occ;
  logic [CNT_W-1:0]     cap_reg;

  logic [1:0]           req_q;
  logic [NODE_BITS-1:0] src_q;
  logic [NODE_BITS-1:0] dst_q;
  logic [TIME_BITS-1:0] time_q;
  logic [TIME_BITS-1:0] lo_q;
  logic [TIME_BITS-1:0] hi_q;
  logic [PTR_W-1:0]     scan_cnt;
  logic [PTR_W-1:0]     rel;
  logic                 dup;
  logic [CNT_W-1:0]     cnt;
  logic [NODE_BITS-1:0] fwd_src;
  logic [NODE_BITS-1:0] fwd_dst;
  logic [TIME_BITS-1:0] fwd_time;

  logic [NODE_BITS-1:0] tap_src;
  logic [NODE_BITS-1:0] tap_dst;
  logic [TIME_BITS-1:0] tap_time;
  ring_ctrl_t           ctrl;

  logic                 cfg_wr;
  logic                 take;
  logic                 live;
  logic                 hit_dup;
  logic                 hit_cnt;
  logic                 hit_head;
  logic [PTR_W-1:0]     rel_init;
  logic [PTR_W-1:0]     rel_inc;
  logic [SUM_W-1:0]     slot_sum;
  logic [PTR_W-1:0]     wr_slot;
  logic [CNT_W-1:0]     live_cap;
  logic                 evict;
  logic [CNT_W-1:0]     drop_n;
  logic [SUM_W-1:0]     head_sum;
  logic [PTR_W-1:0]     head_evict;
  logic [PTR_W-1:0]     head_inc;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_reg) : 32'd0;

  // request handshake
  assign busy = (state != ST_IDLE);
  assign take = start && !busy;

  // tap evaluation: rel is the queue position of the record at the tap, counted from the head
  assign live     = CNT_W'(rel) < occ;
  assign hit_dup  = live && (tap_src == src_q) && (tap_dst == dst_q) && (tap_time == time_q);
  assign hit_cnt  = live && (tap_dst == dst_q) && (tap_time >= lo_q) && (tap_time <= hi_q);
  assign hit_head = live && (rel == '0);

  // ring position bookkeeping
  assign rel_init = (head == '0) ? '0 : PTR_W'(CNT_W'(DEPTH) - CNT_W'(head));
  assign rel_inc  = (rel == PTR_W'(DEPTH - 1)) ? '0 : rel + 1'b1;

  // append slot, head plus occupancy modulo depth
  assign slot_sum = SUM_W'(head) + SUM_W'(occ);
  assign wr_slot  = (slot_sum >= SUM_W'(DEPTH)) ? PTR_W'(slot_sum - SUM_W'(DEPTH))
                                                : PTR_W'(slot_sum);

  // effective capacity, zero as one and saturated at depth
  always_comb begin
    if (cap_reg == '0) begin
      live_cap = CNT_W'(1);
    end else if (cap_reg > CNT_W'(DEPTH)) begin
      live_cap = CNT_W'(DEPTH);
    end else begin
      live_cap = cap_reg;
    end
  end

  // eviction: drop enough old records to leave one free place
  assign evict      = (occ >= live_cap);
  assign drop_n     = occ - live_cap + 1'b1;
  assign head_sum   = SUM_W'(head) + SUM_W'(drop_n);
  assign head_evict = (head_sum >= SUM_W'(DEPTH)) ? PTR_W'(head_sum - SUM_W'(DEPTH))
                                                  : PTR_W'(head_sum);
  assign head_inc   = (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;

  // ring control
  assign ctrl.shift = (state == ST_SCAN);
  assign ctrl.load  = (state == ST_FIN) && (req_q == REQ_ADD) && !dup;

  dpfrc_ring #(
    .DEPTH    (DEPTH),
    .NODE_BITS(NODE_BITS),
    .TIME_BITS(TIME_BITS),
    .PTR_W    (PTR_W)
  ) u_ring (
    .clk     (clk),
    .ctrl    (ctrl),
    .wr_slot (wr_slot),
    .wr_src  (src_q),
    .wr_dst  (dst_q),
    .wr_time (time_q),
    .tap_src (tap_src),
    .tap_dst (tap_dst),
    .tap_time(tap_time)
  );

  // sequencer, queue pointers, capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      head    <= '0;
      occ     <= '0;
      cap_reg <= CNT_W'(DEPTH);
      done    <= 1'b0;
    end else begin
      done <= (state == ST_FIN);
      if (cfg_wr) begin
        cap_reg <= pwdata[CNT_W-1:0];
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_cnt == PTR_W'(DEPTH - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= ST_IDLE;
          case (req_q)
            REQ_ADD: begin
              if (!dup) begin
                if (evict) begin
                  head <= head_evict;
                  occ  <= live_cap;
                end else begin
                  occ <= occ + 1'b1;
                end
              end
            end
            REQ_FWD: begin
              if (occ != '0) begin
                head <= head_inc;
                occ  <= occ - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request capture, scan accumulators and result registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (take) begin
          req_q    <= req_type;
          src_q    <= src_node;
          dst_q    <= dst_node;
          time_q   <= pkt_time;
          lo_q     <= range_start;
          hi_q     <= range_end;
          scan_cnt <= '0;
          rel      <= rel_init;
          dup      <= 1'b0;
          cnt      <= '0;
        end
      end
      ST_SCAN: begin
        scan_cnt <= scan_cnt + 1'b1;
        rel      <= rel_inc;
        if (hit_dup) begin
          dup <= 1'b1;
        end
        if (hit_cnt) begin
          cnt <= cnt + 1'b1;
        end
        if (hit_head) begin
          fwd_src  <= tap_src;
          fwd_dst  <= tap_dst;
          fwd_time <= tap_time;
        end
      end
      ST_FIN: begin
        case (req_q)
          REQ_ADD: begin
            accepted    <= !dup;
            out_src     <= '0;
            out_dst     <= '0;
            out_time    <= '0;
            match_count <= '0;
          end
          REQ_FWD: begin
            if (occ != '0) begin
              accepted <= 1'b1;
              out_src  <= fwd_src;
              out_dst  <= fwd_dst;
              out_time <= fwd_time;
            end else begin
              accepted <= 1'b0;
              out_src  <= '0;
              out_dst  <= '0;
              out_time <= '0;
            end
            match_count <= '0;
          end
          REQ_COUNT: begin
            accepted    <= 1'b0;
            out_src     <= '0;
            out_dst     <= '0;
            out_time    <= '0;
            match_count <= cnt;
          end
          default: begin
            accepted    <= 1'b0;
            out_src     <= '0;
            out_dst     <= '0;
            out_time    <= '0;
            match_count <= '0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // result strobe only follows the commit cycle
  assert property (@(posedge clk) disable iff (rst) done |-> $past(state) == ST_FIN)
    else $error("result strobe without commit");

  // the scan always ends after one full turn of the ring
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && (scan_cnt == PTR_W'(DEPTH - 1)) |=> (state == ST_FIN))
    else $error("ring scan did not end after one turn");

  // a stored add never leaves more records than the effective capacity
  assert property (@(posedge clk) disable iff (rst)
    done && (req_q == REQ_ADD) && accepted |-> (occ <= live_cap))
    else $error("occupancy above capacity after add");

  // a count result never exceeds the records held
  assert property (@(posedge clk) disable iff (rst)
    done && (req_q == REQ_COUNT) |-> !accepted && (match_count <= occ))
    else $error("count result out of range");

  // a forward that returns nothing carries no record
  assert property (@(posedge clk) disable iff (rst)
    done && (req_q == REQ_FWD) && !accepted |-> (out_src == '0) && (out_time == '0))
    else $error("empty forward carries data");

endmodule
